>>> rtl/hamming_two_nearest_matcher_macros.svh
// Shared assertion macros for the matcher.
`ifndef HAMMING_TWO_NEAREST_MATCHER_MACROS_SVH
`define HAMMING_TWO_NEAREST_MATCHER_MACROS_SVH

// Require cons in the same cycle whenever ante holds.
`define HTNM_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Require cons in the cycle after ante holds.
`define HTNM_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Forbid a condition outright.
`define HTNM_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> rtl/htnm_pkg.sv
package htnm_pkg;

	// Default sizing of the reference store.
	localparam int MAX_REFERENCES_DEF       = 1024;
	localparam int WORDS_PER_DESCRIPTOR_DEF = 4;

	// Fixed port geometry.
	localparam int WORD_W     = 64;
	localparam int IN_WORDS   = 4;
	localparam int IN_DESC_W  = WORD_W * IN_WORDS;
	localparam int WPOP_W     = 7;
	localparam int OUT_IDX_W  = 10;
	localparam int OUT_DIST_W = 9;
	localparam int DIST_SAT   = 511;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_QUERY = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef struct packed {
		mode_t                op;
		logic [IN_DESC_W-1:0] desc;
	} cmd_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_DRAIN
	} back_state_t;

	// Count set bits of one byte.
	function automatic logic [3:0] popcnt8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(v[i]);
		end
		return n;
	endfunction

	// Count set bits of one 64-bit word as a sum of byte counts.
	function automatic logic [WPOP_W-1:0] popcnt64(input logic [WORD_W-1:0] v);
		logic [WPOP_W-1:0] n;
		n = '0;
		for (int b = 0; b < 8; b++) begin
			n = n + WPOP_W'(popcnt8(v[b*8 +: 8]));
		end
		return n;
	endfunction

endpackage

>>> rtl/htnm_front.sv
module htnm_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                mode,
	input  logic [63:0]               desc_word0,
	input  logic [63:0]               desc_word1,
	input  logic [63:0]               desc_word2,
	input  logic [63:0]               desc_word3,
	input  logic                      q_full,
	output logic                      push,
	output htnm_pkg::cmd_t            push_cmd
);
	import htnm_pkg::*;

	logic vld_q;
	cmd_t cmd_q;
	logic known;

	// Classify the mode: the unused code is dropped here.
	assign known = (mode == MODE_LOAD) || (mode == MODE_QUERY) || (mode == MODE_CLEAR);

	// Stall only while a held word cannot move into the queue.
	assign busy     = vld_q && q_full;
	assign push     = vld_q && !q_full;
	assign push_cmd = cmd_q;

	// Hold one accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!busy) begin
			vld_q <= start && known;
		end
	end

	// Capture the payload on accept.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q.op   <= mode_t'(mode);
			cmd_q.desc <= {desc_word3, desc_word2, desc_word1, desc_word0};
		end
	end

endmodule

>>> rtl/htnm_queue.sv
`include "hamming_two_nearest_matcher_macros.svh"

module htnm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  htnm_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_vld,
	output htnm_pkg::cmd_t head_cmd
);
	import htnm_pkg::*;

	localparam int DEPTH = 2;

	cmd_t       ent_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'(DEPTH));
	assign head_vld = (cnt_q != 2'd0);
	assign head_cmd = ent_q[rd_ptr_q];

	// Advance pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Store the pushed word.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	`HTNM_IMPLY(a_no_overflow, push, !full, "push into a full queue")
	`HTNM_IMPLY(a_no_underflow, pop, head_vld, "pop from an empty queue")
	`HTNM_NEXT(a_fill, push && !pop, cnt_q == $past(cnt_q) + 2'd1, "occupancy lost a push")

endmodule

>>> rtl/htnm_back.sv
`include "hamming_two_nearest_matcher_macros.svh"

module htnm_back #(
	parameter int MAX_REFERENCES       = htnm_pkg::MAX_REFERENCES_DEF,
	parameter int WORDS_PER_DESCRIPTOR = htnm_pkg::WORDS_PER_DESCRIPTOR_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_vld,
	input  htnm_pkg::cmd_t head_cmd,
	output logic           pop,
	output logic           done,
	output logic [9:0]     best_index,
	output logic [8:0]     best_distance,
	output logic           best_valid,
	output logic [9:0]     second_index,
	output logic [8:0]     second_distance,
	output logic           second_valid
);
	import htnm_pkg::*;

	localparam int W      = WORDS_PER_DESCRIPTOR;
	localparam int DESC_W = W * WORD_W;
	localparam int IDX_W  = $clog2(MAX_REFERENCES);
	localparam int CNT_W  = $clog2(MAX_REFERENCES + 1);
	localparam int DIST_W = $clog2(W * WORD_W + 1);

	back_state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic [DESC_W-1:0] qry_q;
	logic [DESC_W-1:0] row;
	logic [DESC_W-1:0] mem_q [MAX_REFERENCES];

	logic                    take, wr_en, rd_en, emit, qry_start, has_room;
	logic                    v_s1, v_s2, v_s3;
	logic [DESC_W-1:0]       row_s1;
	logic [IDX_W-1:0]        idx_s1, idx_s2, idx_s3;
	logic [WPOP_W-1:0]       pc_s2 [W];
	logic [DIST_W-1:0]       dist_s3, dist_sum;
	logic                    bv_q, sv_q;
	logic [DIST_W-1:0]       bd_q, sd_q;
	logic [IDX_W-1:0]        bi_q, si_q;
	logic [IDX_W+OUT_IDX_W-1:0]   bi_ext, si_ext;
	logic [DIST_W+OUT_DIST_W-1:0] bd_ext, sd_ext;

	// Widen the input descriptor to the stored row; extra words read as zero.
	for (genvar k = 0; k < W; k++) begin : g_row
		if (k < IN_WORDS) begin : g_in
			assign row[k*WORD_W +: WORD_W] = head_cmd.desc[k*WORD_W +: WORD_W];
		end else begin : g_zero
			assign row[k*WORD_W +: WORD_W] = '0;
		end
	end

	assign has_room = (count_q < CNT_W'(MAX_REFERENCES));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (head_vld && head_cmd.op == MODE_QUERY) begin
					state_d = B_SCAN;
				end
			end
			B_SCAN: begin
				if (rd_cnt_q >= count_q) begin
					state_d = B_DRAIN;
				end
			end
			B_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		take      = 1'b0;
		rd_en     = 1'b0;
		emit      = 1'b0;
		case (state_q)
			B_IDLE:  take  = head_vld;
			B_SCAN:  rd_en = (rd_cnt_q < count_q);
			B_DRAIN: emit  = !v_s1 && !v_s2 && !v_s3;
			default: ;
		endcase
	end

	assign pop       = take;
	assign wr_en     = take && (head_cmd.op == MODE_LOAD) && has_room;
	assign qry_start = take && (head_cmd.op == MODE_QUERY);

	// Sequencer, store fill count and scan counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			count_q  <= '0;
			rd_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				count_q <= count_q + 1'b1;
			end else if (take && head_cmd.op == MODE_CLEAR) begin
				count_q <= '0;
			end
			if (qry_start) begin
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	// Reference store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[count_q[IDX_W-1:0]] <= row;
		end
		if (rd_en) begin
			row_s1 <= mem_q[rd_cnt_q[IDX_W-1:0]];
		end
	end

	// Hold the query row for the whole scan.
	always_ff @(posedge clk) begin
		if (qry_start) begin
			qry_q <= row;
		end
	end

	// Sum the per-word counts.
	always_comb begin
		dist_sum = '0;
		for (int k = 0; k < W; k++) begin
			dist_sum = dist_sum + DIST_W'(pc_s2[k]);
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Pipeline payload: index, word counts, distance.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_cnt_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		for (int k = 0; k < W; k++) begin
			pc_s2[k] <= popcnt64(row_s1[k*WORD_W +: WORD_W] ^ qry_q[k*WORD_W +: WORD_W]);
		end
		dist_s3 <= dist_sum;
	end

	// Track the two nearest; strict less-than keeps the earliest on ties.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (qry_start) begin
			bv_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (v_s3) begin
			if (!bv_q || dist_s3 < bd_q) begin
				sv_q <= bv_q;
				bv_q <= 1'b1;
			end else if (!sv_q || dist_s3 < sd_q) begin
				sv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			if (!bv_q || dist_s3 < bd_q) begin
				sd_q <= bd_q;
				si_q <= bi_q;
				bd_q <= dist_s3;
				bi_q <= idx_s3;
			end else if (!sv_q || dist_s3 < sd_q) begin
				sd_q <= dist_s3;
				si_q <= idx_s3;
			end
		end
	end

	// Fit index to the low bits and saturate distance.
	assign bi_ext = {{OUT_IDX_W{1'b0}}, bi_q};
	assign si_ext = {{OUT_IDX_W{1'b0}}, si_q};
	assign bd_ext = {{OUT_DIST_W{1'b0}}, bd_q};
	assign sd_ext = {{OUT_DIST_W{1'b0}}, sd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= emit;
		end
	end

	// Register the result word.
	always_ff @(posedge clk) begin
		if (emit) begin
			best_valid   <= bv_q;
			second_valid <= sv_q;
			best_index   <= bv_q ? bi_ext[OUT_IDX_W-1:0] : '0;
			second_index <= sv_q ? si_ext[OUT_IDX_W-1:0] : '0;
			if (!bv_q) begin
				best_distance <= '0;
			end else if (bd_ext > (DIST_W+OUT_DIST_W)'(DIST_SAT)) begin
				best_distance <= OUT_DIST_W'(DIST_SAT);
			end else begin
				best_distance <= bd_ext[OUT_DIST_W-1:0];
			end
			if (!sv_q) begin
				second_distance <= '0;
			end else if (sd_ext > (DIST_W+OUT_DIST_W)'(DIST_SAT)) begin
				second_distance <= OUT_DIST_W'(DIST_SAT);
			end else begin
				second_distance <= sd_ext[OUT_DIST_W-1:0];
			end
		end
	end

	`HTNM_NEVER(a_cnt_max, count_q > CNT_W'(MAX_REFERENCES), "store count beyond depth")
	`HTNM_IMPLY(a_order, sv_q, bv_q && (bd_q <= sd_q), "second match nearer than best")
	`HTNM_NEXT(a_emit_empty, emit, !v_s3 && state_q == B_IDLE, "result with scan in flight")

endmodule

>>> rtl/hamming_two_nearest_matcher.sv
// With the back end idle, a load or clear updates the store once it has passed the
// front register and the queue; a query scans every stored reference and then raises
// done, also when the store is empty.
// The idle back end takes each load or clear straight from the queue; a query holds it
// until done, scanning one stored row per cycle; a 2-entry queue decouples start.
// Reset clears the store count and all control; store contents stay undefined.
module hamming_two_nearest_matcher #(
	parameter int MAX_REFERENCES       = htnm_pkg::MAX_REFERENCES_DEF,
	parameter int WORDS_PER_DESCRIPTOR = htnm_pkg::WORDS_PER_DESCRIPTOR_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [63:0] desc_word0,
	input  logic [63:0] desc_word1,
	input  logic [63:0] desc_word2,
	input  logic [63:0] desc_word3,
	output logic        done,
	output logic [9:0]  best_index,
	output logic [8:0]  best_distance,
	output logic        best_valid,
	output logic [9:0]  second_index,
	output logic [8:0]  second_distance,
	output logic        second_valid
);
	import htnm_pkg::*;

	logic q_full, push, pop, head_vld;
	cmd_t push_cmd, head_cmd;

	htnm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.desc_word0 (desc_word0),
		.desc_word1 (desc_word1),
		.desc_word2 (desc_word2),
		.desc_word3 (desc_word3),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	htnm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head_vld (head_vld),
		.head_cmd (head_cmd)
	);

	htnm_back #(
		.MAX_REFERENCES       (MAX_REFERENCES),
		.WORDS_PER_DESCRIPTOR (WORDS_PER_DESCRIPTOR)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_vld        (head_vld),
		.head_cmd        (head_cmd),
		.pop             (pop),
		.done            (done),
		.best_index      (best_index),
		.best_distance   (best_distance),
		.best_valid      (best_valid),
		.second_index    (second_index),
		.second_distance (second_distance),
		.second_valid    (second_valid)
	);

endmodule
